// ===== sv/ordered_array_list_assert.svh =====
// assertion macros for the ordered array list checker
// depends on nothing; included by the checker file
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

// same-cycle implication
`define OLST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_array_list check failed");

// next-cycle implication
`define OLST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_array_list check failed");

`endif

// ===== sv/olst_pkg.sv =====
// shared codes and types for the ordered array list
// no dependencies
`timescale 1ns / 1ps

package olst_pkg;

  localparam int KindW   = 3;
  localparam int PosW    = 5;
  localparam int DataW   = 32;
  localparam int StatusW = 2;

  localparam logic [KindW-1:0] KIND_INSERT = 3'd0;
  localparam logic [KindW-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KindW-1:0] KIND_MODIFY = 3'd2;
  localparam logic [KindW-1:0] KIND_READ   = 3'd3;
  localparam logic [KindW-1:0] KIND_FIND   = 3'd4;

  localparam logic [StatusW-1:0] STAT_FOUND     = 2'd0;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY     = 2'd2;

  typedef struct packed {
    logic last;
    logic hit;
  } olst_flags_t;

endpackage

// ===== sv/olst_mem.sv =====
// entry storage: one write port, one read port with registered read data
// depends on olst_pkg
`timescale 1ns / 1ps

module olst_mem
  import olst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/olst_unit.sv =====
// shared step unit: index step, shift target, end-of-range and match compare
// depends on olst_pkg
`timescale 1ns / 1ps

module olst_unit
  import olst_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic [AW-1:0]    idx,
  input  logic             inc,
  input  logic [AW-1:0]    stop,
  input  logic [DataW-1:0] rdata,
  input  logic [DataW-1:0] key,
  output logic [AW-1:0]    idx_next,
  output logic [AW-1:0]    waddr,
  output olst_flags_t      flags
);

  always_comb begin
    idx_next   = inc ? idx + 1'b1 : idx - 1'b1;
    waddr      = inc ? idx - 1'b1 : idx + 1'b1;
    flags.last = (idx == stop);
    flags.hit  = (rdata == key);
  end

endmodule

// ===== sv/ordered_array_list.sv =====
// ordered array list: bounded list of signed 32-bit words, 1-based positions
// an input item carries kind, position and value; each item returns one result item
// with ok, read_value, found_position, search_status, count, is_empty and is_full.
// both channels are valid/ready; an item moves when valid and ready are high together.
// in_ready is high only while the sequencer is idle: one item is worked at a time.
// the entries sit in a single-port-write, single-port-read memory; a shared step
// unit walks them one entry at a time (read, then write or compare).
// insert shifts the entries from the end down to position up by one, then writes
//   the value; remove shifts the later entries down by one; modify writes in place;
//   read reads one entry; find compares from the first entry to a hit or the end.
// refused items skip the memory; the longest item is a find over a full list.
// a finished result waits in the output register; the next item is taken while it
// waits, and a further result holds inside until the receiver takes the first one.
// reset (rst, synchronous) empties the list and drops out_valid; no clearing pass.
// depends on olst_pkg, olst_mem, olst_unit
`timescale 1ns / 1ps

module ordered_array_list
  import olst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KindW-1:0]          kind,
  input  logic [PosW-1:0]           position,
  input  logic signed [DataW-1:0]   value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic signed [DataW-1:0]   read_value,
  output logic [PosW-1:0]           found_position,
  output logic [StatusW-1:0]        search_status,
  output logic [PosW-1:0]           count,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > PosW) ? CW : PosW) + 1;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_FILL, S_READ_RD, S_READ_DATA,
    S_FIND_RD, S_FIND_CMP
  } state_t;

  state_t state;
  logic   pending;

  logic [CW-1:0]     cnt;
  logic [KindW-1:0]  kind_r;
  logic [DataW-1:0]  val_r;
  logic [AW-1:0]     idx, stop, pidx;
  logic              inc;

  logic              st_ok;
  logic [DataW-1:0]  st_rd;
  logic [PosW-1:0]   st_fpos;
  logic [StatusW-1:0] st_status;

  logic [PW-1:0]     pos_ext, cnt_ext;
  logic              ins_ok, acc_ok;
  logic [AW-1:0]     pos_idx;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr, unit_waddr, idx_next;
  logic [DataW-1:0]  wdata, rdata;
  olst_flags_t       flags;
  logic              load_out;

  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(cnt);
  assign pos_idx = AW'(pos_ext - 1'b1);
  assign ins_ok  = (cnt < CapCount) && (position != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign acc_ok  = (position != '0) && (pos_ext <= cnt_ext);

  assign in_ready = (state == S_IDLE) && !pending;
  assign load_out = pending && (!out_valid || out_ready);

  olst_unit #(.AW(AW)) u_unit (
    .idx      (idx),
    .inc      (inc),
    .stop     (stop),
    .rdata    (rdata),
    .key      (val_r),
    .idx_next (idx_next),
    .waddr    (unit_waddr),
    .flags    (flags)
  );

  olst_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = unit_waddr;
    wdata = rdata;
    re    = 1'b0;
    raddr = idx;
    case (state)
      S_SHIFT_RD, S_READ_RD, S_FIND_RD: begin
        re = 1'b1;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = pidx;
        wdata = val_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load_out) begin
        out_valid      <= 1'b1;
        pending        <= 1'b0;
        ok             <= st_ok;
        read_value     <= st_rd;
        found_position <= st_fpos;
        search_status  <= st_status;
        count          <= PosW'(cnt);
        is_empty       <= (cnt == '0);
        is_full        <= (cnt == CapCount);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            kind_r  <= kind;
            val_r   <= value;
            pidx    <= pos_idx;
            st_rd   <= '0;
            st_fpos <= '0;
            case (kind)
              KIND_INSERT: begin
                st_ok     <= 1'b0;
                st_status <= STAT_FOUND;
                pending   <= !ins_ok;
                if (ins_ok) begin
                  if (pos_ext - 1'b1 == cnt_ext) begin
                    state <= S_FILL;
                  end else begin
                    idx   <= AW'(cnt - 1'b1);
                    stop  <= pos_idx;
                    inc   <= 1'b0;
                    state <= S_SHIFT_RD;
                  end
                end
              end
              KIND_REMOVE: begin
                st_status <= STAT_FOUND;
                if (acc_ok && (pos_ext != cnt_ext)) begin
                  st_ok   <= 1'b0;
                  pending <= 1'b0;
                  idx     <= AW'(pos_ext);
                  stop    <= AW'(cnt - 1'b1);
                  inc     <= 1'b1;
                  state   <= S_SHIFT_RD;
                end else begin
                  st_ok   <= acc_ok;
                  pending <= 1'b1;
                  if (acc_ok) begin
                    cnt <= cnt - 1'b1;
                  end
                end
              end
              KIND_MODIFY: begin
                st_ok     <= 1'b0;
                st_status <= STAT_FOUND;
                pending   <= !acc_ok;
                if (acc_ok) begin
                  state <= S_FILL;
                end
              end
              KIND_READ: begin
                st_ok     <= 1'b0;
                st_status <= STAT_FOUND;
                pending   <= !acc_ok;
                if (acc_ok) begin
                  idx   <= pos_idx;
                  state <= S_READ_RD;
                end
              end
              KIND_FIND: begin
                st_ok <= 1'b0;
                if (cnt == '0) begin
                  st_status <= STAT_EMPTY;
                  pending   <= 1'b1;
                end else begin
                  st_status <= STAT_FOUND;
                  pending   <= 1'b0;
                  idx       <= '0;
                  stop      <= AW'(cnt - 1'b1);
                  inc       <= 1'b1;
                  state     <= S_FIND_RD;
                end
              end
              default: begin
                st_ok     <= 1'b0;
                st_status <= STAT_FOUND;
                pending   <= 1'b1;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (flags.last) begin
            if (kind_r == KIND_INSERT) begin
              state <= S_FILL;
            end else begin
              cnt     <= cnt - 1'b1;
              st_ok   <= 1'b1;
              pending <= 1'b1;
              state   <= S_IDLE;
            end
          end else begin
            idx   <= idx_next;
            state <= S_SHIFT_RD;
          end
        end
        S_FILL: begin
          if (kind_r == KIND_INSERT) begin
            cnt <= cnt + 1'b1;
          end
          st_ok   <= 1'b1;
          pending <= 1'b1;
          state   <= S_IDLE;
        end
        S_READ_RD: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          st_rd   <= rdata;
          st_ok   <= 1'b1;
          pending <= 1'b1;
          state   <= S_IDLE;
        end
        S_FIND_RD: begin
          state <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          if (flags.hit) begin
            st_fpos   <= PosW'({1'b0, idx} + 1'b1);
            st_status <= STAT_FOUND;
            pending   <= 1'b1;
            state     <= S_IDLE;
          end else if (flags.last) begin
            st_status <= STAT_NOT_FOUND;
            pending   <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx   <= idx_next;
            state <= S_FIND_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/olst_checker.sv =====
// port-level checks for the ordered array list, bound to the top level
// depends on olst_pkg and ordered_array_list_assert.svh
`timescale 1ns / 1ps
`include "ordered_array_list_assert.svh"

module olst_checker
  import olst_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    ok,
  input logic signed [DataW-1:0] read_value,
  input logic [PosW-1:0]         found_position,
  input logic [StatusW-1:0]      search_status,
  input logic [PosW-1:0]         count,
  input logic                    is_empty
);

  `OLST_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_value))
  `OLST_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `OLST_ASSERT_NOW(a_empty_flag, clk, rst, out_valid, is_empty == (count == '0))
  `OLST_ASSERT_NOW(a_miss_no_pos, clk, rst, out_valid && search_status != STAT_FOUND, found_position == '0)
  `OLST_ASSERT_NOW(a_ok_not_find, clk, rst, out_valid && ok, search_status == STAT_FOUND && found_position == '0)

endmodule

bind ordered_array_list olst_checker u_olst_checker (.*);
